### rtl/ddq_pkg.sv
// ----------------------------------------------------------------------------
// ddq_pkg
// Shared types and constants for the double-ended queue unit.
// ----------------------------------------------------------------------------
package ddq_pkg;

  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 3;
  localparam int STAT_W        = 2;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_REAR  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_REAR   = 3'd3,
    FN_CLEAR      = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } stat_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RESULT = 1'b1
  } state_t;

endpackage

### rtl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed words in a ring memory; reports front, rear, count,
// empty flag and status after every operation.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | func, data
//  out     | out_valid/out_stall | front_value, rear_value, count, is_empty,
//          |                     | status
//
// each operation runs through the idle and result states: the accept cycle
// updates pointers, writes the ring and issues one read; the next cycle takes
// the read data into the output register.
// no clearing pass after reset: values read from unwritten ring entries never reach the outputs.
// a stalled result holds; a new word is taken only once the result slot frees.
module double_ended_queue_unit
  import ddq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [DATA_W-1:0] data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] rear_value,
  output logic [CW-1:0]            count,
  output logic                     is_empty,
  output logic [STAT_W-1:0]        status
);

  localparam int SW = IW + 1;

  // ring memory
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  state_t state, state_next;

  logic [IW-1:0]            head, head_next;
  logic [CW-1:0]            cnt, cnt_next;
  logic signed [DATA_W-1:0] front_q, front_next;
  logic signed [DATA_W-1:0] rear_q, rear_next;
  logic                     pend_front, pend_front_next;
  logic                     pend_rear, pend_rear_next;
  stat_t                    stat_q, stat_next;

  logic              in_fire;
  logic              load;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [IW-1:0]     raddr;
  logic [SW-1:0]     sum;
  logic [SW-1:0]     sum_wrap;
  logic [SW-1:0]     last_sum;
  logic [SW-1:0]     last_wrap;

  logic signed [DATA_W-1:0] front_res;
  logic signed [DATA_W-1:0] rear_res;

  // control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = out_valid && out_stall;
        if (in_valid && !in_stall) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        load       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_fire = (state == ST_IDLE) && in_valid && !in_stall;

  // ring position: head plus offset, folded once
  always_comb begin
    sum       = {1'b0, head} + SW'(cnt);
    sum_wrap  = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
    last_sum  = sum - SW'(2);
    last_wrap = (last_sum >= SW'(DEPTH)) ? (last_sum - SW'(DEPTH)) : last_sum;
  end

  always_comb begin
    head_next       = head;
    cnt_next        = cnt;
    front_next      = front_q;
    rear_next       = rear_q;
    pend_front_next = 1'b0;
    pend_rear_next  = 1'b0;
    stat_next       = STAT_DONE;
    we              = 1'b0;
    waddr           = head;
    raddr           = head;
    case (func)
      FN_PUSH_FRONT: begin
        if (cnt == CW'(DEPTH)) begin
          stat_next = STAT_OVERFLOW;
        end else begin
          head_next  = (head == '0) ? IW'(DEPTH - 1) : head - IW'(1);
          waddr      = head_next;
          we         = 1'b1;
          cnt_next   = cnt + CW'(1);
          front_next = data;
          if (cnt == '0) begin
            rear_next = data;
          end
        end
      end
      FN_PUSH_REAR: begin
        if (cnt == CW'(DEPTH)) begin
          stat_next = STAT_OVERFLOW;
        end else begin
          waddr     = IW'(sum_wrap);
          we        = 1'b1;
          cnt_next  = cnt + CW'(1);
          rear_next = data;
          if (cnt == '0) begin
            front_next = data;
          end
        end
      end
      FN_POP_FRONT: begin
        if (cnt == '0) begin
          stat_next = STAT_UNDERFLOW;
        end else begin
          head_next       = (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);
          cnt_next        = cnt - CW'(1);
          raddr           = head_next;
          pend_front_next = 1'b1;
        end
      end
      FN_POP_REAR: begin
        if (cnt == '0) begin
          stat_next = STAT_UNDERFLOW;
        end else begin
          cnt_next = cnt - CW'(1);
          // new rear sits two below head plus old count
          if (cnt > CW'(1)) begin
            raddr          = IW'(last_wrap);
            pend_rear_next = 1'b1;
          end
        end
      end
      FN_CLEAR: begin
        head_next = '0;
        cnt_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we && in_fire) begin
      mem[waddr] <= data;
    end
    rdata <= mem[raddr];
  end

  // result view once the read data is in
  always_comb begin
    front_res = pend_front ? $signed(rdata) : front_q;
    rear_res  = pend_rear  ? $signed(rdata) : rear_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      cnt        <= '0;
      pend_front <= 1'b0;
      pend_rear  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        head       <= head_next;
        cnt        <= cnt_next;
        pend_front <= pend_front_next;
        pend_rear  <= pend_rear_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      front_q <= front_next;
      rear_q  <= rear_next;
      stat_q  <= stat_next;
    end else if (load) begin
      front_q <= front_res;
      rear_q  <= rear_res;
    end
    if (load) begin
      front_value <= (cnt == '0) ? -32'sd1 : front_res;
      rear_value  <= (cnt == '0) ? -32'sd1 : rear_res;
      count       <= cnt;
      is_empty    <= (cnt == '0);
      status      <= stat_q;
    end
  end

endmodule

### rtl/ddq_checker.sv
// ----------------------------------------------------------------------------
// ddq_checker
// Port-level checks for the double-ended queue unit, bound into double_ended_queue_unit.
// ----------------------------------------------------------------------------
module ddq_checker
  import ddq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [FUNC_W-1:0]        func,
  input logic signed [DATA_W-1:0] data,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] front_value,
  input logic signed [DATA_W-1:0] rear_value,
  input logic [CW-1:0]            count,
  input logic                     is_empty,
  input logic [STAT_W-1:0]        status
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(front_value) &&
      $stable(rear_value) && $stable(count) && $stable(status))
    else $error("result word changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)) && (count <= CW'(DEPTH)))
    else $error("count and empty flag disagree");

  a_empty_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> front_value == -32'sd1 && rear_value == -32'sd1)
    else $error("empty queue shows a value");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FN_CLEAR |->
      ##2 out_valid && count == '0 && status == STAT_DONE)
    else $error("clear did not empty the queue");

  a_single_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && count == CW'(1) |-> front_value == rear_value)
    else $error("single entry shows two values");

endmodule

bind double_ended_queue_unit ddq_checker #(.DEPTH(DEPTH)) u_ddq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .func        (func),
  .data        (data),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .front_value (front_value),
  .rear_value  (rear_value),
  .count       (count),
  .is_empty    (is_empty),
  .status      (status)
);
